// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while reset is asserted
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on aclk, off while reset is asserted
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/kcl_pkg.sv =====
// types, codes and reset constants of the keypad combination lock
`default_nettype none

package kcl_pkg;

    localparam int CODE_DIGITS_DEF = 5;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 32;

    localparam logic [31:0] TIMEOUT_RST    = 32'd60000000;
    localparam logic [3:0]  FAIL_LIMIT_RST = 4'd3;
    localparam logic [3:0]  FAIL_MAX       = 4'd15;

    localparam logic [3:0] KEY_LOCK    = 4'd1;
    localparam logic [3:0] KEY_NEWCODE = 4'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT = 8'd1;

    typedef enum logic [1:0] {
        MODE_UNLOCKED = 2'd0,
        MODE_LOCKED   = 2'd1,
        MODE_NEWCODE  = 2'd2,
        MODE_LOCKOUT  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_UNLOCK  = 3'd1,
        EV_WRONG   = 3'd2,
        EV_TIMEOUT = 3'd3,
        EV_CHANGED = 3'd4,
        EV_KEPT    = 3'd5
    } event_t;

    // factory code 2,4,1,5,3, zero past the fifth digit
    function automatic logic [3:0] reset_digit(input int idx);
        logic [3:0] d;
        case (idx)
            0:       d = 4'd2;
            1:       d = 4'd4;
            2:       d = 4'd1;
            3:       d = 4'd5;
            4:       d = 4'd3;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/keypad_combination_lock_top.sv =====
// keypad combination lock: key and tick items in, one status item out per input item
// result path: an accepted item is held in the input register, its result in the result register
// throughput: one item per cycle; the whole state update is one pass of compare/count logic
// back pressure: s_tready follows the result register, so a stalled result holds one item
// reset: aresetn synchronous active low; code back to 2,4,1,5,3, mode unlocked, counts cleared
// reset: timeout_ticks back to 60000000 and failure_limit back to 3
`default_nettype none

module keypad_combination_lock_top #(
    parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    // configuration write channel
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [kcl_pkg::CFG_DATA_W-1:0] cfg_data,
    // input items
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [7:0]                     s_tdata,   // [3:0] key, [7:4] zero
    input  wire                            s_tuser,   // [0] mode (0 key press, 1 tick)
    // result items
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [15:0]                    m_tdata    // [1:0] lock_mode, [4:2] event_res,
                                                      // [5] lock_led, [9:6] failures,
                                                      // [15:10] zero
);
    import kcl_pkg::*;

    // position counter width, at least one bit
    localparam int POS_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(CODE_DIGITS - 1);

    // configuration registers
    logic [31:0] timeout_ticks_reg;
    logic [3:0]  failure_limit_reg;

    // input register
    logic        in_valid_reg;
    logic        in_tick_reg;
    logic [3:0]  in_key_reg;

    // lock state
    mode_t            mode_reg, mode_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       fail_reg, fail_next;
    logic             phase_reg, phase_next;
    logic             mism_reg, mism_next;
    logic [31:0]      tick_reg, tick_next;
    logic             running_reg, running_next;
    logic [3:0]       stored_code_reg [CODE_DIGITS];
    logic [3:0]       first_entry_reg [CODE_DIGITS];

    // result register
    logic        m_valid_reg;
    mode_t       res_mode_reg;
    event_t      res_event_reg;
    logic        res_led_reg;
    logic [3:0]  res_fail_reg;

    // pipeline control
    logic        out_free;
    logic        advance;

    // per-item logic
    event_t      ev;
    logic        fe_we;
    logic        code_copy;
    logic        last_digit;
    logic [3:0]  code_digit;
    logic [3:0]  entry_digit;
    logic [3:0]  fail_inc;
    logic [31:0] tick_inc;
    logic        mism_any;

    assign cfg_ready = 1'b1;

    // the result slot is free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign last_digit  = (pos_reg == POS_LAST);
    assign code_digit  = stored_code_reg[pos_reg];
    assign entry_digit = first_entry_reg[pos_reg];
    assign fail_inc    = (fail_reg == FAIL_MAX) ? fail_reg : fail_reg + 4'd1;
    assign tick_inc    = tick_reg + 32'd1;
    assign mism_any    = mism_reg || (in_key_reg != entry_digit);

    // next state for the item in the input register
    always_comb begin
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        fail_next    = fail_reg;
        phase_next   = phase_reg;
        mism_next    = mism_reg;
        tick_next    = tick_reg;
        running_next = running_reg;
        ev           = EV_NONE;
        fe_we        = 1'b0;
        code_copy    = 1'b0;
        if (advance) begin
            unique case (mode_reg)
                MODE_UNLOCKED: begin
                    if (!in_tick_reg) begin
                        if (in_key_reg == KEY_LOCK) begin
                            mode_next    = MODE_LOCKED;
                            pos_next     = '0;
                            running_next = 1'b0;
                            tick_next    = '0;
                        end else if (in_key_reg == KEY_NEWCODE) begin
                            mode_next    = MODE_NEWCODE;
                            pos_next     = '0;
                            running_next = 1'b0;
                            tick_next    = '0;
                            phase_next   = 1'b0;
                            mism_next    = 1'b0;
                        end
                    end
                end
                MODE_LOCKED: begin
                    if (!in_tick_reg) begin
                        // first digit of an attempt starts the entry timer
                        if (pos_reg == '0) begin
                            running_next = 1'b1;
                            tick_next    = '0;
                        end
                        if (in_key_reg == code_digit) begin
                            if (last_digit) begin
                                mode_next    = MODE_UNLOCKED;
                                pos_next     = '0;
                                running_next = 1'b0;
                                tick_next    = '0;
                                fail_next    = '0;
                                ev           = EV_UNLOCK;
                            end else begin
                                pos_next = pos_reg + POS_W'(1);
                            end
                        end else begin
                            pos_next     = '0;
                            running_next = 1'b0;
                            tick_next    = '0;
                            fail_next    = fail_inc;
                            ev           = EV_WRONG;
                            if (fail_inc >= failure_limit_reg) begin
                                mode_next = MODE_LOCKOUT;
                            end
                        end
                    end else if (running_reg) begin
                        tick_next = tick_inc;
                        if (tick_inc >= timeout_ticks_reg) begin
                            pos_next     = '0;
                            running_next = 1'b0;
                            tick_next    = '0;
                            ev           = EV_TIMEOUT;
                        end
                    end
                end
                MODE_NEWCODE: begin
                    if (!in_tick_reg) begin
                        if (!phase_reg) begin
                            fe_we = 1'b1;
                            if (last_digit) begin
                                phase_next = 1'b1;
                                pos_next   = '0;
                            end else begin
                                pos_next = pos_reg + POS_W'(1);
                            end
                        end else if (!last_digit) begin
                            mism_next = mism_any;
                            pos_next  = pos_reg + POS_W'(1);
                        end else begin
                            pos_next   = '0;
                            phase_next = 1'b0;
                            mism_next  = 1'b0;
                            mode_next  = MODE_UNLOCKED;
                            if (!mism_any) begin
                                code_copy = 1'b1;
                                ev        = EV_CHANGED;
                            end else begin
                                ev = EV_KEPT;
                            end
                        end
                    end
                end
                MODE_LOCKOUT: begin
                    // held until reset
                end
            endcase
        end
    end

    // control, state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg <= TIMEOUT_RST;
            failure_limit_reg <= FAIL_LIMIT_RST;
            in_valid_reg      <= 1'b0;
            mode_reg          <= MODE_UNLOCKED;
            pos_reg           <= '0;
            fail_reg          <= '0;
            phase_reg         <= 1'b0;
            mism_reg          <= 1'b0;
            tick_reg          <= '0;
            running_reg       <= 1'b0;
            for (int i = 0; i < CODE_DIGITS; i++) begin
                stored_code_reg[i] <= reset_digit(i);
            end
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_TIMEOUT:    timeout_ticks_reg <= cfg_data;
                    REG_FAIL_LIMIT: failure_limit_reg <= cfg_data[3:0];
                    default: begin
                        // unmapped index, write dropped
                    end
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            fail_reg    <= fail_next;
            phase_reg   <= phase_next;
            mism_reg    <= mism_next;
            tick_reg    <= tick_next;
            running_reg <= running_next;
            if (code_copy) begin
                stored_code_reg <= first_entry_reg;
            end
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_tick_reg <= s_tuser;
            in_key_reg  <= s_tdata[3:0];
        end
        if (fe_we) begin
            first_entry_reg[pos_reg] <= in_key_reg;
        end
        if (advance) begin
            res_mode_reg  <= mode_next;
            res_event_reg <= ev;
            res_led_reg   <= (mode_next == MODE_LOCKED) || (mode_next == MODE_LOCKOUT);
            res_fail_reg  <= fail_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, res_fail_reg, res_led_reg, res_event_reg, res_mode_reg};

endmodule

`default_nettype wire

// ===== hdl/kcl_checker.sv =====
// port-level checker for the keypad combination lock, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module kcl_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire  [15:0] m_tdata
);
    import kcl_pkg::*;

    logic [1:0] out_mode;
    logic [2:0] out_event;
    logic       out_led;
    logic [3:0] out_fail;

    assign out_mode  = m_tdata[1:0];
    assign out_event = m_tdata[4:2];
    assign out_led   = m_tdata[5];
    assign out_fail  = m_tdata[9:6];

    // a stalled result item keeps its payload
    `ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // lamp agrees with the reported mode
    `ASSERT_IMPL(a_led_mode, m_tvalid,
        out_led == ((out_mode == MODE_LOCKED) || (out_mode == MODE_LOCKOUT)))

    // an unlock leaves the block unlocked with the failure count cleared
    `ASSERT_IMPL(a_unlock_clears, m_tvalid && (out_event == EV_UNLOCK),
        (out_mode == MODE_UNLOCKED) && (out_fail == 4'd0))

    // a wrong digit has always been counted
    `ASSERT_IMPL(a_wrong_counted, m_tvalid && (out_event == EV_WRONG),
        (out_fail != 4'd0) && ((out_mode == MODE_LOCKED) || (out_mode == MODE_LOCKOUT)))

endmodule

bind keypad_combination_lock_top kcl_checker u_kcl_checker (.*);

`default_nettype wire
